@@ hw/rtl/lpdp_pkg.sv @@
// Shared constants and types for the positioned decimal print block.
// Used by the BCD cell, the BCD chain and the top level; no dependencies.
`default_nettype none

package lpdp_pkg;

	// Display geometry and HD44780 command / character codes
	localparam int unsigned COLUMNS      = 16;
	localparam logic [7:0]  ROW1_BASE    = 8'h40;
	localparam logic [7:0]  SET_ADDR_CMD = 8'h80;
	localparam logic [7:0]  ASCII_ZERO   = 8'h30;

	// Conversion geometry: 32-bit binary in, ten decimal digits out
	localparam int unsigned NUM_BITS   = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned CNT_W      = $clog2(NUM_BITS);
	localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

	// Per-cycle command to every cell of the chain
	typedef struct packed {
		logic clear;      // zero the digit
		logic shift_bin;  // add-3 correction, then shift one binary bit in
		logic shift_dig;  // take the neighbour's digit (move digits towards the top)
	} cell_ctrl_t;

endpackage : lpdp_pkg

`default_nettype wire

@@ hw/rtl/lpdp_bcd_cell.sv @@
// One decimal digit of the shift-and-add-3 converter.
// Depends on lpdp_pkg for the control struct.
`default_nettype none

module lpdp_bcd_cell (
	input  wire logic              clk,
	input  wire lpdp_pkg::cell_ctrl_t ctrl,
	input  wire logic              bit_in,    // binary bit from the lower neighbour
	input  wire logic [3:0]        dig_in,    // digit from the lower neighbour
	output logic                   carry_out, // binary bit to the upper neighbour
	output logic [3:0]             digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// correct by three where the digit would pass nine after doubling
	always_comb begin
		adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.shift_bin) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift_dig) begin
			digit_q <= dig_in;
		end
	end

endmodule : lpdp_bcd_cell

`default_nettype wire

@@ hw/rtl/lpdp_bcd_chain.sv @@
// Row of BCD cells: binary bits enter at the bottom, digits leave at the top.
// Depends on lpdp_pkg and lpdp_bcd_cell.
`default_nettype none

module lpdp_bcd_chain (
	input  wire logic                 clk,
	input  wire lpdp_pkg::cell_ctrl_t ctrl,
	input  wire logic                 bin_bit,  // next binary bit, MSB first
	output logic [3:0]                top_digit,
	output logic                      overflow  // carry out of the top cell
);

	logic [lpdp_pkg::NUM_DIGITS:0] carry;
	logic [3:0]                    dig [lpdp_pkg::NUM_DIGITS:0];

	assign carry[0] = bin_bit;
	assign dig[0]   = 4'd0;

	for (genvar i = 0; i < lpdp_pkg::NUM_DIGITS; i++) begin : g_cell
		lpdp_bcd_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.bit_in    (carry[i]),
			.dig_in    (dig[i]),
			.carry_out (carry[i+1]),
			.digit     (dig[i+1])
		);
	end

	assign top_digit = dig[lpdp_pkg::NUM_DIGITS];
	assign overflow  = carry[lpdp_pkg::NUM_DIGITS];

endmodule : lpdp_bcd_chain

`default_nettype wire

@@ hw/rtl/lcd_positioned_decimal_print.sv @@
// Positioned decimal print: address command byte, then decimal ASCII digits.
// Sequence: accept, shift the 32-bit number into the BCD chain MSB first, discard leading
// zeros while keeping at least one digit, then register the command beat; digits
// follow one per cycle while the sink keeps tready high. Skipped zeros and printed digits
// always add up to ten. An item at a bad position is taken and dropped. One item is in
// flight at a time.
// Reset: arst_n clears the sequencer and the output register asynchronously.
`default_nettype none

module lcd_positioned_decimal_print #(
	parameter int unsigned COLUMNS = lpdp_pkg::COLUMNS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // row[7:0], col[15:8], number[47:16]

	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // byte_out[7:0]
	output logic             m_tuser,   // is_data[0]: 0 command, 1 character
	output logic             m_tlast    // last beat of the item's run
);

	localparam int unsigned CNT_W = lpdp_pkg::CNT_W;
	localparam int unsigned REM_W = lpdp_pkg::REM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_CMD,
		ST_DIG
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;      // conversion bit counter
	logic [REM_W-1:0]      rem_q;      // digits still held in the chain
	logic [lpdp_pkg::NUM_BITS-1:0] num_q;
	logic [7:0]            cmd_q;

	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;

	logic [7:0]            in_row;
	logic [7:0]            in_col;
	logic [lpdp_pkg::NUM_BITS-1:0] in_number;
	logic                  in_beat;
	logic                  pos_ok;
	logic [7:0]            addr;
	logic                  out_free;
	logic                  out_load;

	lpdp_pkg::cell_ctrl_t  chain_ctrl;
	logic [3:0]            top_digit;
	logic                  chain_ovf;

	// unpack the input beat
	assign in_row    = s_tdata[7:0];
	assign in_col    = s_tdata[15:8];
	assign in_number = s_tdata[47:16];

	// only idle takes a beat; a held output beat does not block the input side
	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;

	// rows 0 and 1 only, column inside the display
	assign pos_ok = ((in_row == 8'd0) || (in_row == 8'd1)) &&
	                (in_col < 8'(COLUMNS));
	assign addr   = ((in_row == 8'd1) ? lpdp_pkg::ROW1_BASE : 8'd0) + in_col;

	// output register may be loaded when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = ((state_q == ST_CMD) || (state_q == ST_DIG)) && out_free;

	// drive the digit chain from the sequencer state
	always_comb begin
		chain_ctrl           = '0;
		chain_ctrl.clear     = in_beat && pos_ok;
		chain_ctrl.shift_bin = (state_q == ST_CONV);
		chain_ctrl.shift_dig = ((state_q == ST_SKIP) && (top_digit == 4'd0) &&
		                        (rem_q > REM_W'(1))) ||
		                       ((state_q == ST_DIG) && out_free);
	end

	lpdp_bcd_chain u_chain (
		.clk       (clk),
		.ctrl      (chain_ctrl),
		.bin_bit   (num_q[lpdp_pkg::NUM_BITS-1]),
		.top_digit (top_digit),
		.overflow  (chain_ovf)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rem_q      <= '0;
			num_q      <= '0;
			cmd_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			// load a new beat, or drop the held one once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// an item at a bad position is taken and dropped
					if (in_beat && pos_ok) begin
						num_q   <= in_number;
						cmd_q   <= lpdp_pkg::SET_ADDR_CMD | {1'b0, addr[6:0]};
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					// one binary bit into the chain per cycle, MSB first
					num_q <= {num_q[lpdp_pkg::NUM_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(lpdp_pkg::NUM_BITS - 1)) begin
						rem_q   <= REM_W'(lpdp_pkg::NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// discard leading zeros, keep at least one digit
					if ((top_digit == 4'd0) && (rem_q > REM_W'(1))) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					if (out_free) begin
						m_tdata_q  <= cmd_q;
						m_tuser_q  <= 1'b0;
						m_tlast_q  <= 1'b0;
						state_q    <= ST_DIG;
					end
				end
				ST_DIG: begin
					// top digit out as ASCII, chain advances by one digit
					if (out_free) begin
						m_tdata_q  <= lpdp_pkg::ASCII_ZERO + {4'd0, top_digit};
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= (rem_q == REM_W'(1));
						rem_q      <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// a 32-bit value never carries out of the ten-digit chain
	a_no_chain_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !chain_ovf)
		else $error("BCD chain overflow during conversion");

	// every character beat is a decimal ASCII digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata[7:4] == 4'h3) && (m_tdata[3:0] <= 4'd9)))
		else $error("character beat is not a decimal digit");

	// the command beat never closes a run
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> !m_tlast)
		else $error("command beat flagged last");

	// digit shift-out never runs with the chain empty
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIG) || (state_q == ST_SKIP)) |-> (rem_q != '0))
		else $error("digit count underflow");

endmodule : lcd_positioned_decimal_print

`default_nettype wire
